[rtl/core/ptu_pkg.sv]
// Package for the particle table update block: stored entry layout, sequencer
// states and the saturating Q8.8 vector add. No dependencies.
package ptu_pkg;

	localparam int unsigned PTU_MAX_PARTICLES = 64;
	localparam int unsigned PTU_IN_BITS       = 288;
	localparam int unsigned PTU_OUT_BITS      = 112;

	// One stored particle, kept as a single memory word.
	typedef struct packed {
		logic [63:0] color;    // end color high, start color low
		logic [31:0] rotation; // end angle high, start angle low
		logic [31:0] scale;    // end scale high, start scale low
		logic [15:0] life;
		logic [15:0] age;
		logic [47:0] accel;
		logic [47:0] vel;
		logic [47:0] pos;
	} ent_t;

	localparam int unsigned PTU_ENT_BITS = $bits(ent_t);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_C_RD_ORD,
		ST_C_RD_MAIN,
		ST_C_CHK,
		ST_U_START,
		ST_U_RD_ORD,
		ST_U_RD_MAIN,
		ST_U_LOAD,
		ST_U_DIV,
		ST_U_LERP,
		ST_U_OUT
	} st_t;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Per-component saturating add of three packed signed Q8.8 values.
	function automatic logic [47:0] sat_add3(input logic [47:0] a, input logic [47:0] b);
		logic [47:0] r;
		logic signed [16:0] s;
		for (int c = 0; c < 3; c++) begin
			s = {a[16*c+15], a[16*c +: 16]} + {b[16*c+15], b[16*c +: 16]};
			if (s > 17'sd32767) begin
				r[16*c +: 16] = 16'h7FFF;
			end else if (s < -17'sd32768) begin
				r[16*c +: 16] = 16'h8000;
			end else begin
				r[16*c +: 16] = s[15:0];
			end
		end
		return r;
	endfunction

endpackage

[rtl/core/particle_table_update.sv]
// Top level of the particle table update block: sequencer, shared divider and
// shared multiplier. Depends on ptu_pkg and ptu_ram.
//
// Usage. The slave stream takes one command beat: tuser carries the opcode
// (0 adds a particle, 1 is a frame tick) and tdata the particle fields. An add
// is absorbed while the slave side stays ready and produces nothing; it is
// dropped if the table already holds MAX_PARTICLES particles. A tick first
// walks the live list from oldest to newest and drops expired particles, then
// walks it newest first, updating each particle and sending one vertex beat on
// the master stream, with tlast on the final one. For each vertex the block
// reads the order and particle memories and writes the moved particle back,
// runs a 32-step restoring divider for the progress value, performs six
// interpolations through one multiplier and then offers the vertex beat. The
// slave side stays not ready until every vertex of a tick has been taken. While
// the receiver stalls, the vertex beat holds and the walk waits. Reset clears
// the particle count and the slot map; the stored particle data need no
// clearing. A tick with no live particles returns to idle without any output.
module particle_table_update
	import ptu_pkg::*;
#(
	parameter int unsigned MAX_PARTICLES = PTU_MAX_PARTICLES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// lifetime, start_position, start_velocity, acceleration, scale_pair,
	// rotation_pair, start_color, end_color
	input  logic [PTU_IN_BITS-1:0]  s_axis_tdata,
	// opcode
	input  logic                    s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// vertex_position, vertex_scale, vertex_rotation, vertex_color
	output logic [PTU_OUT_BITS-1:0] m_axis_tdata,
	// last_vertex
	output logic                    m_axis_tlast
);

	localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);

	st_t st_q, st_d;

	logic [CW-1:0]            live_q, kept_q, k_q;
	logic [MAX_PARTICLES-1:0] used_q;
	logic [AW-1:0]            slot_q;
	ent_t                     ent_q;
	logic [15:0]              rem_q;
	logic [31:0]              dvd_q;
	logic [16:0]              quot_q;
	logic [4:0]               dcnt_q;
	logic [2:0]               li_q;
	logic                     ph_q;
	logic signed [35:0]       prod_q;
	logic signed [17:0]       base_q;
	logic [15:0]              res_q [6];

	// Memory ports.
	logic          m_we, o_we;
	logic [AW-1:0] m_waddr, m_raddr, o_waddr, o_raddr;
	ent_t          m_wdata, m_rdata;
	logic [AW-1:0] o_wdata, o_rdata;

	ptu_ram #(.WIDTH(PTU_ENT_BITS), .DEPTH(MAX_PARTICLES)) u_main (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	ptu_ram #(.WIDTH(AW), .DEPTH(MAX_PARTICLES)) u_order (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
		.raddr(o_raddr), .rdata(o_rdata)
	);

	// Input fields.
	ent_t   in_ent;
	logic   in_beat;
	assign in_ent.life     = s_axis_tdata[15:0];
	assign in_ent.age      = 16'd0;
	assign in_ent.pos      = s_axis_tdata[63:16];
	assign in_ent.vel      = s_axis_tdata[111:64];
	assign in_ent.accel    = s_axis_tdata[159:112];
	assign in_ent.scale    = s_axis_tdata[191:160];
	assign in_ent.rotation = s_axis_tdata[223:192];
	assign in_ent.color    = s_axis_tdata[287:224];
	assign in_beat = s_axis_tvalid && s_axis_tready;

	// Lowest free slot.
	logic [AW-1:0] free_slot;
	always_comb begin
		free_slot = '0;
		for (int i = MAX_PARTICLES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_slot = AW'(i);
			end
		end
	end

	// Motion and age update of the particle just read.
	ent_t         upd_ent;
	logic [47:0]  new_vel;
	always_comb begin
		new_vel           = sat_add3(m_rdata.vel, m_rdata.accel);
		upd_ent           = m_rdata;
		upd_ent.vel       = new_vel;
		upd_ent.pos       = sat_add3(m_rdata.pos, new_vel);
		upd_ent.age       = m_rdata.age + 16'd1;
	end

	// Divider step: shift in one dividend bit, subtract when it fits.
	logic [16:0] div_r;
	logic        div_fit;
	assign div_r   = {rem_q, dvd_q[31]};
	assign div_fit = div_r >= {1'b0, ent_q.life};

	// Interpolation operand select.
	logic signed [17:0] lo_s, lo_e;
	always_comb begin
		case (li_q)
			3'd0: begin
				lo_s = {2'b00, ent_q.scale[15:0]};
				lo_e = {2'b00, ent_q.scale[31:16]};
			end
			3'd1: begin
				lo_s = {{2{ent_q.rotation[15]}}, ent_q.rotation[15:0]};
				lo_e = {{2{ent_q.rotation[31]}}, ent_q.rotation[31:16]};
			end
			3'd2, 3'd3, 3'd4, 3'd5: begin
				lo_s = {10'd0, ent_q.color[8*(li_q-3'd2) +: 8]};
				lo_e = {10'd0, ent_q.color[32 + 8*(li_q-3'd2) +: 8]};
			end
			default: begin
				lo_s = '0;
				lo_e = '0;
			end
		endcase
	end

	logic signed [17:0] lo_d;
	logic signed [17:0] lo_t;
	logic signed [17:0] lerp_sum;
	assign lo_d     = lo_e - lo_s;
	assign lo_t     = {1'b0, quot_q};
	assign lerp_sum = base_q + 18'(prod_q >>> 16);

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_beat && s_axis_tuser == OP_TICK) begin
					st_d = ST_C_RD_ORD;
				end
			end
			ST_C_RD_ORD:  st_d = (k_q == live_q) ? ST_U_START : ST_C_RD_MAIN;
			ST_C_RD_MAIN: st_d = ST_C_CHK;
			ST_C_CHK:     st_d = ST_C_RD_ORD;
			ST_U_START:   st_d = (kept_q == '0) ? ST_IDLE : ST_U_RD_ORD;
			ST_U_RD_ORD:  st_d = ST_U_RD_MAIN;
			ST_U_RD_MAIN: st_d = ST_U_LOAD;
			ST_U_LOAD:    st_d = ST_U_DIV;
			ST_U_DIV:     st_d = (dcnt_q == 5'd0) ? ST_U_LERP : ST_U_DIV;
			ST_U_LERP:    st_d = (ph_q && li_q == 3'd5) ? ST_U_OUT : ST_U_LERP;
			ST_U_OUT: begin
				if (m_axis_tready) begin
					st_d = (k_q == '0) ? ST_IDLE : ST_U_RD_ORD;
				end
			end
			default:      st_d = ST_IDLE;
		endcase
	end

	// Outputs and memory controls.
	always_comb begin
		s_axis_tready = (st_q == ST_IDLE);
		m_axis_tvalid = (st_q == ST_U_OUT);
		m_axis_tlast  = (k_q == '0);
		m_axis_tdata  = {res_q[5][7:0], res_q[4][7:0], res_q[3][7:0], res_q[2][7:0],
			res_q[1], res_q[0], ent_q.pos};
		m_we    = 1'b0;
		m_waddr = slot_q;
		m_wdata = upd_ent;
		m_raddr = o_rdata;
		o_we    = 1'b0;
		o_waddr = kept_q[AW-1:0];
		o_wdata = slot_q;
		o_raddr = k_q[AW-1:0];
		case (st_q)
			ST_IDLE: begin
				if (in_beat && s_axis_tuser == OP_ADD && live_q < CW'(MAX_PARTICLES)) begin
					m_we    = 1'b1;
					m_waddr = free_slot;
					m_wdata = in_ent;
					o_we    = 1'b1;
					o_waddr = live_q[AW-1:0];
					o_wdata = free_slot;
				end
			end
			ST_C_CHK: begin
				o_we = (m_rdata.age < m_rdata.life);
			end
			ST_U_LOAD: begin
				m_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			live_q <= '0;
			kept_q <= '0;
			k_q    <= '0;
			used_q <= '0;
			dcnt_q <= '0;
			li_q   <= '0;
			ph_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			case (st_q)
				ST_IDLE: begin
					k_q    <= '0;
					kept_q <= '0;
					if (m_we) begin
						used_q[free_slot] <= 1'b1;
						live_q            <= live_q + CW'(1);
					end
				end
				ST_C_CHK: begin
					k_q <= k_q + CW'(1);
					if (o_we) begin
						kept_q <= kept_q + CW'(1);
					end else begin
						used_q[slot_q] <= 1'b0;
					end
				end
				ST_U_START: begin
					live_q <= kept_q;
					k_q    <= kept_q - CW'(1);
				end
				ST_U_LOAD: begin
					dcnt_q <= 5'd31;
					li_q   <= '0;
					ph_q   <= 1'b0;
				end
				ST_U_DIV: begin
					dcnt_q <= dcnt_q - 5'd1;
				end
				ST_U_LERP: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						li_q <= li_q + 3'd1;
					end
				end
				ST_U_OUT: begin
					if (m_axis_tready && k_q != '0) begin
						k_q <= k_q - CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_C_RD_MAIN, ST_U_RD_MAIN: begin
				slot_q <= o_rdata;
			end
			ST_U_LOAD: begin
				ent_q  <= upd_ent;
				rem_q  <= '0;
				dvd_q  <= {upd_ent.age, 16'd0};
				quot_q <= '0;
			end
			ST_U_DIV: begin
				dvd_q  <= {dvd_q[30:0], 1'b0};
				quot_q <= {quot_q[15:0], div_fit};
				rem_q  <= div_fit ? 16'(div_r - {1'b0, ent_q.life}) : div_r[15:0];
			end
			ST_U_LERP: begin
				if (!ph_q) begin
					prod_q <= lo_d * lo_t;
					base_q <= lo_s;
				end else begin
					res_q[li_q] <= lerp_sum[15:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/ptu_ram.sv]
// Generic single-write, single-read memory with registered read data.
// Depends on nothing.
module ptu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/ptu_checker.sv]
// Port-level checker for particle_table_update, attached by a bind statement.
// Depends on ptu_pkg for the output stream width and the opcode values.
module ptu_checker
	import ptu_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_axis_tvalid,
	input logic                    s_axis_tready,
	input logic                    s_axis_tuser,
	input logic                    m_axis_tvalid,
	input logic                    m_axis_tready,
	input logic [PTU_OUT_BITS-1:0] m_axis_tdata,
	input logic                    m_axis_tlast
);

	// A stalled vertex beat holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled vertex beat changed");

	// The block never takes a command while a vertex is on offer.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("ready while vertex pending");

	// An add produces no vertex.
	a_add: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_ADD |=> !m_axis_tvalid)
		else $error("vertex after add");

	// After the final vertex of a tick the block is idle again.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
		else $error("not idle after last vertex");

endmodule

bind particle_table_update ptu_checker u_ptu_checker (.*);
